// ----- rtl/core/sla_pkg.sv -----
// shared types and constants of the stripe layout allocator
// no dependencies; used by sla_ctrl, sla_datapath and the top level
`timescale 1ns / 1ps

package sla_pkg;

  // defaults for the top-level parameters
  localparam int MAX_TARGETS_DEF = 16;
  localparam int BYTE_BITS_DEF   = 48;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int NUM_W    = 4;
  localparam int TAG_W    = 16;

  // most result words one request may give, and a counter that holds it
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = 5;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEPS = 4;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REQ    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STRIPE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSIZE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic                accept;
    logic                clear;
    logic                append;
    logic                load_req;
    logic                div_step;
    logic                rd;
    logic                adv;
    logic                take;
    logic                push_final;
    logic                push_stat;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic size_zero;
    logic elig_zero;
    logic div_done;
    logic walk_end;
    logic hit;
    logic slots_done;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/stripe_layout_allocator_unit.sv -----
// stripe layout allocator: input word channel, result word channel
// instantiates sla_ctrl and sla_datapath; depends on sla_pkg
`timescale 1ns / 1ps

// usage
//   input words (in_valid/in_ready) carry func: clear the target table, append one
//   target (online flag, capacity, used bytes), or request a layout of file_size
//   result words (out_valid/out_ready) carry one stripe each, or a single status word;
//   the final word of a request has last set, tag_out echoes request_tag
// timing
//   one word is worked on at a time; in_ready is high only while the block is idle
//   clear and append give no result (append to a full table
//   gives one status word)
//   a layout request is accepted, divided in the divider, then walks the table entry
//   by entry (table read, then compare) until its slots are filled or the walk runs
//   off the end of the table, and then releases the final word
// reset
//   the table empties (entry and eligible counts clear), the output register drops
//   valid; table contents are not cleared and need no clearing pass
// backpressure
//   one stripe is held ahead of the output register so last can be set on it;
//   when out_ready stays low the walk pauses at the next found stripe, and the
//   block returns to idle as soon as the final word sits in the output register
module stripe_layout_allocator_unit #(
  parameter int MAX_TARGETS = sla_pkg::MAX_TARGETS_DEF,
  parameter int BYTE_BITS   = sla_pkg::BYTE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sla_pkg::FUNC_W-1:0]    func,
  input  logic                          target_online,
  input  logic [BYTE_BITS-1:0]          target_capacity,
  input  logic [BYTE_BITS-1:0]          target_used,
  input  logic [BYTE_BITS-1:0]          file_size,
  input  logic [sla_pkg::TAG_W-1:0]     request_tag,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sla_pkg::STATUS_W-1:0]  status,
  output logic [sla_pkg::NUM_W-1:0]     stripe_number,
  output logic [BYTE_BITS-1:0]          stripe_offset,
  output logic [BYTE_BITS-1:0]          stripe_length,
  output logic [sla_pkg::NUM_W-1:0]     target_index,
  output logic [sla_pkg::TAG_W-1:0]     tag_out,
  output logic                          last
);

  // commands from the sequencer, status back from the datapath
  sla_pkg::cmd_t cmd;
  sla_pkg::sts_t sts;

  // sequencer: accept, divide, walk, release
  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, divider, walker and output register
  sla_datapath #(
    .MAX_TARGETS (MAX_TARGETS),
    .BYTE_BITS   (BYTE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .target_online   (target_online),
    .target_capacity (target_capacity),
    .target_used     (target_used),
    .file_size       (file_size),
    .request_tag     (request_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .stripe_number   (stripe_number),
    .stripe_offset   (stripe_offset),
    .stripe_length   (stripe_length),
    .target_index    (target_index),
    .tag_out         (tag_out),
    .last            (last)
  );

endmodule

// ----- rtl/core/sla_ctrl.sv -----
// control state machine of the stripe layout allocator
// depends on sla_pkg (cmd_t, sts_t, function and status codes)
`timescale 1ns / 1ps

module sla_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sla_pkg::FUNC_W-1:0] func,
  input  sla_pkg::sts_t             sts,
  output sla_pkg::cmd_t             cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_RD   = 6'b000100,
    S_EV   = 6'b001000,
    S_FIN  = 6'b010000,
    S_STAT = 6'b100000
  } state_t;

  state_t                        state, state_next;
  logic [sla_pkg::STATUS_W-1:0]  code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    code <= code_next;
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (func)
            sla_pkg::FUNC_CLEAR: begin
              cmd.clear = 1'b1;
            end
            sla_pkg::FUNC_APPEND: begin
              if (sts.full) begin
                code_next  = sla_pkg::ST_FULL;
                state_next = S_STAT;
              end else begin
                cmd.append = 1'b1;
              end
            end
            sla_pkg::FUNC_REQ: begin
              cmd.load_req = 1'b1;
              priority if (sts.size_zero) begin
                code_next  = sla_pkg::ST_NOSIZE;
                state_next = S_STAT;
              end else if (sts.elig_zero) begin
                code_next  = sla_pkg::ST_NOFREE;
                state_next = S_STAT;
              end else begin
                state_next = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.walk_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_EV;
        end
      end
      S_EV: begin
        if (sts.hit) begin
          // a held stripe must leave before the new one replaces it
          if (!sts.pend_valid || sts.out_free) begin
            cmd.take   = 1'b1;
            state_next = sts.slots_done ? S_FIN : S_RD;
          end
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.push_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/sla_datapath.sv -----
// target table, divider, stripe walker and output register
// depends on sla_pkg (cmd_t, sts_t, widths, status codes)
`timescale 1ns / 1ps

module sla_datapath #(
  parameter int MAX_TARGETS = sla_pkg::MAX_TARGETS_DEF,
  parameter int BYTE_BITS   = sla_pkg::BYTE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sla_pkg::cmd_t                 cmd,
  output sla_pkg::sts_t                 sts,
  input  logic                          target_online,
  input  logic [BYTE_BITS-1:0]          target_capacity,
  input  logic [BYTE_BITS-1:0]          target_used,
  input  logic [BYTE_BITS-1:0]          file_size,
  input  logic [sla_pkg::TAG_W-1:0]     request_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sla_pkg::STATUS_W-1:0]  status,
  output logic [sla_pkg::NUM_W-1:0]     stripe_number,
  output logic [BYTE_BITS-1:0]          stripe_offset,
  output logic [BYTE_BITS-1:0]          stripe_length,
  output logic [sla_pkg::NUM_W-1:0]     target_index,
  output logic [sla_pkg::TAG_W-1:0]     tag_out,
  output logic                          last
);

  localparam int SW     = $clog2(MAX_TARGETS + 1);
  localparam int IW     = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int RES_W  = sla_pkg::RES_W;
  localparam int CW     = (SW > RES_W) ? SW : RES_W;
  localparam int STEPS  = sla_pkg::DIV_STEPS;
  localparam int ITERS  = (BYTE_BITS + STEPS - 1) / STEPS;
  localparam int DIV_W  = ITERS * STEPS;
  localparam int DCW    = $clog2(ITERS);

  typedef struct packed {
    logic [sla_pkg::NUM_W-1:0] num;
    logic [BYTE_BITS-1:0]      off;
    logic [BYTE_BITS-1:0]      len;
    logic [sla_pkg::NUM_W-1:0] idx;
  } stripe_t;

  // table: free bytes of each target, worked out when it is appended
  logic [BYTE_BITS-1:0] free_mem [MAX_TARGETS];
  logic [BYTE_BITS-1:0] rdata;
  logic [SW-1:0]        entry_count;
  logic [SW-1:0]        elig_count;

  logic [BYTE_BITS:0]   diff_in;
  logic [BYTE_BITS-1:0] free_in;

  // request and divider state
  logic [sla_pkg::TAG_W-1:0] tag_q;
  logic [SW-1:0]             slots_q;
  logic [RES_W-1:0]          cap_q;
  logic [DIV_W-1:0]          quo;
  logic [SW-1:0]             rem_q;
  logic [DCW-1:0]            div_cnt;
  logic [DIV_W-1:0]          quo_next;
  logic [SW-1:0]             rem_next;
  logic [SW-1:0]             slots_in;
  logic [CW-1:0]             slots_w;
  logic [RES_W-1:0]          cap_in;

  // walk state
  logic [SW-1:0]        cnt;
  logic [RES_W-1:0]     emitted;
  logic [BYTE_BITS-1:0] offset;
  logic [BYTE_BITS-1:0] base;
  logic [BYTE_BITS-1:0] extent;
  logic                 plus_one;
  stripe_t              pend;
  logic                 pend_valid;

  logic                 out_load;
  logic                 out_free;

  // free space of the word being appended: zero when offline or overbooked
  assign diff_in = {1'b0, target_capacity} - {1'b0, target_used};
  assign free_in = (target_online && !diff_in[BYTE_BITS]) ? diff_in[BYTE_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      free_mem[entry_count[IW-1:0]] <= free_in;
    end
    if (cmd.rd) begin
      rdata <= free_mem[cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      elig_count  <= '0;
    end else if (cmd.clear) begin
      entry_count <= '0;
      elig_count  <= '0;
    end else if (cmd.append) begin
      entry_count <= entry_count + SW'(1);
      elig_count  <= elig_count + SW'(free_in != '0);
    end
  end

  // slot count and its cap on result words
  assign slots_in = (file_size < BYTE_BITS'(elig_count)) ? SW'(file_size) : elig_count;
  assign slots_w  = CW'(slots_in);
  assign cap_in   = (slots_w > CW'(sla_pkg::MAX_RESULTS)) ? RES_W'(sla_pkg::MAX_RESULTS)
                                                            : RES_W'(slots_w);

  // restoring division, a few narrow steps per cycle
  always_comb begin
    logic [SW:0] t;
    logic        qb;
    quo_next = quo;
    rem_next = rem_q;
    for (int k = 0; k < STEPS; k++) begin
      t = {rem_next, quo_next[DIV_W-1]};
      qb = (t >= {1'b0, slots_q});
      rem_next = qb ? SW'(t - {1'b0, slots_q}) : t[SW-1:0];
      quo_next = {quo_next[DIV_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_q <= request_tag;
    end
    if (cmd.load_req) begin
      slots_q <= slots_in;
      cap_q   <= cap_in;
      quo     <= DIV_W'(file_size);
      rem_q   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= quo_next;
      rem_q   <= rem_next;
      div_cnt <= div_cnt + DCW'(1);
    end
  end

  // stripe walk
  assign base     = quo[BYTE_BITS-1:0];
  assign plus_one = (CW'(emitted) < CW'(rem_q));
  assign extent   = base + BYTE_BITS'(plus_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load_req) begin
      pend_valid <= 1'b0;
    end else if (cmd.take) begin
      pend_valid <= 1'b1;
    end
    if (cmd.load_req) begin
      cnt     <= '0;
      emitted <= '0;
      offset  <= '0;
    end else if (cmd.take) begin
      cnt      <= cnt + SW'(1);
      emitted  <= emitted + RES_W'(1);
      offset   <= offset + extent;
      pend.num <= sla_pkg::NUM_W'(emitted);
      pend.off <= offset;
      pend.len <= extent;
      pend.idx <= sla_pkg::NUM_W'(cnt);
    end else if (cmd.adv) begin
      cnt <= cnt + SW'(1);
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;
  assign out_load = (cmd.take && pend_valid) || cmd.push_final || cmd.push_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      tag_out <= tag_q;
      if (cmd.push_stat || (cmd.push_final && !pend_valid)) begin
        status        <= cmd.push_stat ? cmd.code : sla_pkg::ST_EMPTY;
        stripe_number <= '0;
        stripe_offset <= '0;
        stripe_length <= '0;
        target_index  <= '0;
        last          <= 1'b1;
      end else begin
        status        <= sla_pkg::ST_STRIPE;
        stripe_number <= pend.num;
        stripe_offset <= pend.off;
        stripe_length <= pend.len;
        target_index  <= pend.idx;
        last          <= cmd.push_final;
      end
    end
  end

  assign sts.full       = (entry_count == SW'(MAX_TARGETS));
  assign sts.size_zero  = (file_size == '0);
  assign sts.elig_zero  = (elig_count == '0);
  assign sts.div_done   = (div_cnt == DCW'(ITERS - 1));
  assign sts.walk_end   = (cnt == entry_count);
  assign sts.hit        = (rdata >= extent);
  assign sts.slots_done = (RES_W'(emitted + RES_W'(1)) >= cap_q);
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  // a held stripe is only pushed into a free output register
  assert property (@(posedge clk) disable iff (rst)
    (cmd.take && pend_valid) |-> out_free)
    else $error("stripe pushed over a waiting result");

  // eligible targets are a subset of the table, which holds at most MAX_TARGETS
  assert property (@(posedge clk) disable iff (rst)
    (elig_count <= entry_count) && (entry_count <= SW'(MAX_TARGETS)))
    else $error("table counters out of range");

  // every stripe carries at least one byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sla_pkg::ST_STRIPE) |-> (stripe_length != '0))
    else $error("empty stripe emitted");

  // a request never emits more stripes than its cap
  assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (emitted < cap_q))
    else $error("stripe count exceeds slot cap");

endmodule
